// ===== hw/rtl/rag_dd_pkg.sv =====
// shared types, codes and defaults of the rag deadlock detector
package rag_dd_pkg;

    localparam int MAX_ENTRIES_DEF = 16;
    localparam int ID_WIDTH_DEF    = 8;
    localparam int FIELD_ID_WIDTH  = 8;
    localparam int STATUS_WIDTH    = 4;

    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_REQUEST = 1'b1;

    typedef enum logic [STATUS_WIDTH-1:0] {
        ST_ALLOCATED   = 4'd0,
        ST_PROC_EXISTS = 4'd1,
        ST_RES_EXISTS  = 4'd2,
        ST_FULL        = 4'd3,
        ST_EMPTY       = 4'd4,
        ST_NO_PROC     = 4'd5,
        ST_NO_RES      = 4'd6,
        ST_WAITING     = 4'd7,
        ST_REQUESTED   = 4'd8
    } status_t;

    typedef struct packed {
        logic                      opcode;
        logic [FIELD_ID_WIDTH-1:0] process_id;
        logic [FIELD_ID_WIDTH-1:0] resource_id;
    } in_item_t;

    typedef struct packed {
        logic [STATUS_WIDTH-1:0] status;
        logic                    cycle_found;
    } out_item_t;

    typedef enum logic [2:0] {
        CS_IDLE,
        CS_MATCH,
        CS_EXEC,
        CS_WALK,
        CS_RESP
    } ctrl_state_t;

    typedef struct packed {
        logic capture;
        logic match;
        logic exec;
        logic walk_step;
        logic result_load;
    } dp_cmd_t;

    typedef struct packed {
        logic need_walk;
        logic walk_done;
        logic out_free;
    } dp_status_t;

endpackage

// ===== hw/rtl/rag_deadlock_detector_core.sv =====
// top level of the rag deadlock detector
//
// item channel (item_valid, item_ready, item) carries allocate and request
// transactions; result channel (result_valid, result_ready, result) returns
// exactly one status transaction per item, in order.
// item_ready is high only while the controller is idle; one item is in work
// at a time.
// an item takes match and decision cycles, then a request that is granted
// walks the wait-for chain one slot per cycle through the wait slot memory,
// up to entry count plus one steps.
// from acceptance an item passes the match, exec and resp states, a granted
// request also the walk state, and its result is then loaded into the output
// register; the next item is accepted only once that load returns it to idle.
// the result sits in an output register; a new item is taken while it waits,
// and that item's work stalls only at its own result until the receiver
// takes the previous transaction.
// reset empties the table, clears all wait edges and the sticky cycle flag;
// the block accepts items right after reset.
module rag_deadlock_detector_core #(
    parameter int MAX_ENTRIES = rag_dd_pkg::MAX_ENTRIES_DEF,
    parameter int ID_WIDTH    = rag_dd_pkg::ID_WIDTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_ready,
    input  rag_dd_pkg::in_item_t  item,
    output logic                  result_valid,
    input  logic                  result_ready,
    output rag_dd_pkg::out_item_t result
);

    rag_dd_pkg::dp_cmd_t    dp_cmd;
    rag_dd_pkg::dp_status_t dp_status;

    rag_dd_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .dp_status  (dp_status),
        .dp_cmd     (dp_cmd)
    );

    rag_dd_datapath #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .ID_WIDTH    (ID_WIDTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .result       (result),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .dp_cmd       (dp_cmd),
        .dp_status    (dp_status)
    );

endmodule

// ===== hw/rtl/rag_dd_ctrl.sv =====
// controller state machine of the rag deadlock detector
module rag_dd_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    output logic                   item_ready,
    input  rag_dd_pkg::dp_status_t dp_status,
    output rag_dd_pkg::dp_cmd_t    dp_cmd
);

    rag_dd_pkg::ctrl_state_t state_reg;
    rag_dd_pkg::ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rag_dd_pkg::CS_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        dp_cmd     = '0;
        item_ready = 1'b0;
        case (state_reg)
            rag_dd_pkg::CS_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    dp_cmd.capture = 1'b1;
                    state_next     = rag_dd_pkg::CS_MATCH;
                end
            end
            rag_dd_pkg::CS_MATCH:
            begin
                dp_cmd.match = 1'b1;
                state_next   = rag_dd_pkg::CS_EXEC;
            end
            rag_dd_pkg::CS_EXEC:
            begin
                dp_cmd.exec = 1'b1;
                state_next  = dp_status.need_walk ? rag_dd_pkg::CS_WALK
                                                  : rag_dd_pkg::CS_RESP;
            end
            rag_dd_pkg::CS_WALK:
            begin
                dp_cmd.walk_step = 1'b1;
                if (dp_status.walk_done)
                begin
                    state_next = rag_dd_pkg::CS_RESP;
                end
            end
            rag_dd_pkg::CS_RESP:
            begin
                if (dp_status.out_free)
                begin
                    dp_cmd.result_load = 1'b1;
                    state_next         = rag_dd_pkg::CS_IDLE;
                end
            end
            default:
            begin
                state_next = rag_dd_pkg::CS_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/rag_dd_datapath.sv =====
// slot table, id matching, wait chain walker and result register
module rag_dd_datapath #(
    parameter int MAX_ENTRIES = rag_dd_pkg::MAX_ENTRIES_DEF,
    parameter int ID_WIDTH    = rag_dd_pkg::ID_WIDTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  rag_dd_pkg::in_item_t   item,
    output rag_dd_pkg::out_item_t  result,
    output logic                   result_valid,
    input  logic                   result_ready,
    input  rag_dd_pkg::dp_cmd_t    dp_cmd,
    output rag_dd_pkg::dp_status_t dp_status
);

    localparam int IW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int XW = (ID_WIDTH > rag_dd_pkg::FIELD_ID_WIDTH) ? ID_WIDTH
                                                               : rag_dd_pkg::FIELD_ID_WIDTH;

    rag_dd_pkg::in_item_t  item_reg;
    logic [CW-1:0]         count_reg;
    logic [ID_WIDTH-1:0]   proc_ids_reg [MAX_ENTRIES];
    logic [ID_WIDTH-1:0]   res_ids_reg  [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] wait_valid_reg;
    logic [IW-1:0]         wait_slot_mem [MAX_ENTRIES];
    logic [IW-1:0]         cur_reg;
    logic [CW-1:0]         step_reg;
    logic [IW-1:0]         ps_reg;
    logic                  ps_hit_reg;
    logic [IW-1:0]         rs_reg;
    logic                  rs_hit_reg;
    logic [3:0]            status_reg;
    logic                  cycle_seen_reg;
    rag_dd_pkg::out_item_t result_reg;
    logic                  result_valid_reg;

    logic [XW-1:0]         pid_ext;
    logic [XW-1:0]         rid_ext;
    logic [ID_WIDTH-1:0]   pid_key;
    logic [ID_WIDTH-1:0]   rid_key;
    logic                  ps_hit;
    logic [IW-1:0]         ps_idx;
    logic                  rs_hit;
    logic [IW-1:0]         rs_idx;
    rag_dd_pkg::status_t   status_code;
    logic                  do_alloc;
    logic                  do_request;
    logic                  walk_hit;
    logic                  walk_stop;
    logic                  out_free;

    assign pid_ext = XW'(item_reg.process_id);
    assign rid_ext = XW'(item_reg.resource_id);
    assign pid_key = pid_ext[ID_WIDTH-1:0];
    assign rid_key = rid_ext[ID_WIDTH-1:0];

    // first used slot holding each id
    always_comb
    begin
        ps_hit = 1'b0;
        ps_idx = '0;
        rs_hit = 1'b0;
        rs_idx = '0;
        for (int k = MAX_ENTRIES - 1; k >= 0; k--)
        begin
            if ((CW'(k) < count_reg) && (proc_ids_reg[k] == pid_key))
            begin
                ps_hit = 1'b1;
                ps_idx = IW'(k);
            end
            if ((CW'(k) < count_reg) && (res_ids_reg[k] == rid_key))
            begin
                rs_hit = 1'b1;
                rs_idx = IW'(k);
            end
        end
    end

    always_comb
    begin
        do_alloc    = 1'b0;
        do_request  = 1'b0;
        status_code = rag_dd_pkg::ST_ALLOCATED;
        if (item_reg.opcode == rag_dd_pkg::OP_ALLOC)
        begin
            if (ps_hit_reg)
            begin
                status_code = rag_dd_pkg::ST_PROC_EXISTS;
            end
            else if (rs_hit_reg)
            begin
                status_code = rag_dd_pkg::ST_RES_EXISTS;
            end
            else if (count_reg == CW'(MAX_ENTRIES))
            begin
                status_code = rag_dd_pkg::ST_FULL;
            end
            else
            begin
                status_code = rag_dd_pkg::ST_ALLOCATED;
                do_alloc    = 1'b1;
            end
        end
        else
        begin
            if (count_reg == '0)
            begin
                status_code = rag_dd_pkg::ST_EMPTY;
            end
            else if (!ps_hit_reg)
            begin
                status_code = rag_dd_pkg::ST_NO_PROC;
            end
            else if (!rs_hit_reg)
            begin
                status_code = rag_dd_pkg::ST_NO_RES;
            end
            else if (wait_valid_reg[ps_reg])
            begin
                status_code = rag_dd_pkg::ST_WAITING;
            end
            else
            begin
                status_code = rag_dd_pkg::ST_REQUESTED;
                do_request  = 1'b1;
            end
        end
    end

    // target test comes before the edge test, the new edge of ps is already set
    assign walk_hit  = (cur_reg == ps_reg);
    assign walk_stop = walk_hit || !wait_valid_reg[cur_reg] || (step_reg == count_reg);
    assign out_free  = !result_valid_reg || result_ready;

    assign dp_status.need_walk = do_request;
    assign dp_status.walk_done = walk_stop;
    assign dp_status.out_free  = out_free;

    always_ff @(posedge clk)
    begin
        if (dp_cmd.capture)
        begin
            item_reg <= item;
        end
        if (dp_cmd.match)
        begin
            ps_reg     <= ps_idx;
            ps_hit_reg <= ps_hit;
            rs_reg     <= rs_idx;
            rs_hit_reg <= rs_hit;
        end
        if (dp_cmd.exec)
        begin
            status_reg <= status_code;
        end
        if (dp_cmd.exec && do_alloc)
        begin
            proc_ids_reg[count_reg[IW-1:0]] <= pid_key;
            res_ids_reg[count_reg[IW-1:0]]  <= rid_key;
        end
        if (dp_cmd.result_load)
        begin
            result_reg.status      <= status_reg;
            result_reg.cycle_found <= (status_reg == rag_dd_pkg::ST_REQUESTED) &&
                                      cycle_seen_reg;
        end
    end

    // wait slot memory, read combinationally into the walk pointer register
    always_ff @(posedge clk)
    begin
        if (dp_cmd.exec && do_request)
        begin
            wait_slot_mem[ps_reg] <= rs_reg;
            cur_reg               <= rs_reg;
            step_reg              <= '0;
        end
        else if (dp_cmd.walk_step && !walk_stop)
        begin
            cur_reg  <= wait_slot_mem[cur_reg];
            step_reg <= step_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg        <= '0;
            wait_valid_reg   <= '0;
            cycle_seen_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (dp_cmd.exec && do_alloc)
            begin
                count_reg                         <= count_reg + CW'(1);
                wait_valid_reg[count_reg[IW-1:0]] <= 1'b0;
            end
            if (dp_cmd.exec && do_request)
            begin
                wait_valid_reg[ps_reg] <= 1'b1;
            end
            if (dp_cmd.walk_step && walk_stop && walk_hit)
            begin
                cycle_seen_reg <= 1'b1;
            end
            if (dp_cmd.result_load)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    assign result       = result_reg;
    assign result_valid = result_valid_reg;

endmodule

// ===== tb/tb_rag_deadlock_detector_core.sv =====
// testbench of the rag deadlock detector core: allocate and request transactions checked against a predictor
module tb_rag_deadlock_detector_core;
    import rag_dd_pkg::*;

    localparam int MAX_ENTRIES = MAX_ENTRIES_DEF;
    localparam int ID_WIDTH    = ID_WIDTH_DEF;
    localparam logic [FIELD_ID_WIDTH-1:0] ID_MASK =
        FIELD_ID_WIDTH'((64'd1 << ID_WIDTH) - 64'd1);
    localparam int RANDOM_ITEMS = 850;
    localparam int MAX_WAIT     = 18;
    localparam int DRAIN_CYCLES = MAX_ENTRIES + 24;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PRINT_LIMIT  = 40;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      item_valid = 1'b0;
    logic      item_ready;
    in_item_t  item = '0;
    logic      result_valid;
    logic      result_ready = 1'b0;
    out_item_t result;

    rag_deadlock_detector_core #(
        .MAX_ENTRIES(MAX_ENTRIES),
        .ID_WIDTH   (ID_WIDTH)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .item        (item),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result      (result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predictor state
    int                        slots_used;
    logic [FIELD_ID_WIDTH-1:0] slot_pid [MAX_ENTRIES];
    logic [FIELD_ID_WIDTH-1:0] slot_rid [MAX_ENTRIES];
    bit                        slot_waits [MAX_ENTRIES];
    int                        slot_target [MAX_ENTRIES];
    bit                        deadlock_seen;

    in_item_t  item_backlog [$];
    out_item_t pending_status [$];
    logic [FIELD_ID_WIDTH-1:0] pid_pool [$];
    logic [FIELD_ID_WIDTH-1:0] rid_pool [$];

    int        error_count;
    int        cycle_count;
    bit        item_taken;
    bit        result_taken;
    int        send_gap;
    int        recv_stall;
    int        send_mode;
    int        recv_mode;
    out_item_t want;

    function automatic out_item_t predict_grant(in_item_t it);
        logic [FIELD_ID_WIDTH-1:0] pid;
        logic [FIELD_ID_WIDTH-1:0] rid;
        int        ps;
        int        rs;
        int        cur;
        bit        closes;
        out_item_t r;
        pid = it.process_id & ID_MASK;
        rid = it.resource_id & ID_MASK;
        ps = MAX_ENTRIES;
        rs = MAX_ENTRIES;
        closes = 1'b0;
        r.cycle_found = 1'b0;
        for (int k = 0; k < slots_used; k++)
        begin
            if (ps == MAX_ENTRIES && slot_pid[k] == pid)
                ps = k;
            if (rs == MAX_ENTRIES && slot_rid[k] == rid)
                rs = k;
        end
        if (it.opcode == OP_ALLOC)
        begin
            if (ps < MAX_ENTRIES)
                r.status = ST_PROC_EXISTS;
            else if (rs < MAX_ENTRIES)
                r.status = ST_RES_EXISTS;
            else if (slots_used >= MAX_ENTRIES)
                r.status = ST_FULL;
            else
            begin
                slot_pid[slots_used]    = pid;
                slot_rid[slots_used]    = rid;
                slot_waits[slots_used]  = 1'b0;
                slot_target[slots_used] = 0;
                slots_used++;
                r.status = ST_ALLOCATED;
            end
        end
        else
        begin
            if (slots_used == 0)
                r.status = ST_EMPTY;
            else if (ps >= MAX_ENTRIES)
                r.status = ST_NO_PROC;
            else if (rs >= MAX_ENTRIES)
                r.status = ST_NO_RES;
            else if (slot_waits[ps])
                r.status = ST_WAITING;
            else
            begin
                slot_waits[ps]  = 1'b1;
                slot_target[ps] = rs;
                cur = rs;
                for (int steps = 0; steps <= slots_used; steps++)
                begin
                    if (cur == ps)
                    begin
                        closes = 1'b1;
                        break;
                    end
                    if (!slot_waits[cur])
                        break;
                    cur = slot_target[cur];
                end
                if (closes)
                    deadlock_seen = 1'b1;
                r.status = ST_REQUESTED;
                r.cycle_found = deadlock_seen;
            end
        end
        return r;
    endfunction

    function automatic bit id_known(bit is_res, logic [FIELD_ID_WIDTH-1:0] id);
        if (is_res)
        begin
            foreach (rid_pool[k])
                if (rid_pool[k] == id)
                    return 1'b1;
        end
        else
        begin
            foreach (pid_pool[k])
                if (pid_pool[k] == id)
                    return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic [FIELD_ID_WIDTH-1:0] pick_id(bit is_res);
        if (is_res && rid_pool.size() > 0)
            return rid_pool[$urandom_range(0, rid_pool.size() - 1)];
        if (!is_res && pid_pool.size() > 0)
            return pid_pool[$urandom_range(0, pid_pool.size() - 1)];
        return FIELD_ID_WIDTH'($urandom_range(0, 255));
    endfunction

    // keeps the id pools in step with the table so that random requests hit live entries
    function automatic void queue_item(logic op, logic [FIELD_ID_WIDTH-1:0] pid,
                                       logic [FIELD_ID_WIDTH-1:0] rid);
        item_backlog.push_back('{opcode: op, process_id: pid, resource_id: rid});
        if (op == OP_ALLOC && !id_known(1'b0, pid) && !id_known(1'b1, rid)
            && pid_pool.size() < MAX_ENTRIES)
        begin
            pid_pool.push_back(pid);
            rid_pool.push_back(rid);
        end
    endfunction

    function automatic int draw_wait(inout int mode);
        if ($urandom_range(0, 39) == 0)
            mode = $urandom_range(0, 2);
        case (mode)
            0:       return 0;
            1:       return $urandom_range(0, MAX_WAIT);
            default: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, MAX_WAIT) : 0;
        endcase
    endfunction

    task automatic report_mismatch(string what);
        if (error_count < PRINT_LIMIT)
            $display("mismatch at cycle %0d: %s", cycle_count, what);
        error_count++;
    endtask

    // driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!item_valid || item_taken)
            begin
                if (send_gap > 0)
                begin
                    item_valid <= 1'b0;
                    send_gap--;
                end
                else if (item_backlog.size() > 0)
                begin
                    item       <= item_backlog.pop_front();
                    item_valid <= 1'b1;
                    send_gap   = draw_wait(send_mode);
                end
                else
                    item_valid <= 1'b0;
            end
            if (result_taken)
                recv_stall = draw_wait(recv_mode);
            if (recv_stall > 0)
            begin
                result_ready <= 1'b0;
                recv_stall--;
            end
            else
                result_ready <= 1'b1;
        end
    end

    // monitor and checker
    always @(posedge clk)
    begin
        item_taken   <= item_valid && item_ready;
        result_taken <= result_valid && result_ready;
        if (rst_n)
        begin
            if (cycle_count >= CYCLE_LIMIT)
            begin
                $display("tb_rag_deadlock_detector_core NOT OK");
                $finish;
            end
            else
            begin
                cycle_count <= cycle_count + 1;
                if (item_valid && item_ready)
                    pending_status.push_back(predict_grant(item));
                if (result_valid && result_ready)
                begin
                    if (pending_status.size() == 0)
                        report_mismatch("result transaction with nothing pending");
                    else
                    begin
                        want = pending_status.pop_front();
                        if (result.status !== want.status)
                            report_mismatch($sformatf("status %0d, expected %0d",
                                                      result.status, want.status));
                        if (result.cycle_found !== want.cycle_found)
                            report_mismatch($sformatf("cycle_found %0b, expected %0b",
                                                      result.cycle_found,
                                                      want.cycle_found));
                    end
                end
            end
        end
    end

    initial
    begin
        int                        sel;
        logic [FIELD_ID_WIDTH-1:0] pid;
        logic [FIELD_ID_WIDTH-1:0] rid;
        slots_used    = 0;
        deadlock_seen = 1'b0;
        error_count   = 0;
        cycle_count   = 0;
        item_taken    = 1'b0;
        result_taken  = 1'b0;
        send_gap      = 0;
        recv_stall    = 0;
        send_mode     = 2;
        recv_mode     = 2;
        foreach (slot_waits[k])
        begin
            slot_waits[k]  = 1'b0;
            slot_target[k] = 0;
        end

        // directed part
        queue_item(OP_REQUEST, 8'h00, 8'h00);
        queue_item(OP_ALLOC,   8'h00, 8'hFF);
        queue_item(OP_ALLOC,   8'hFF, 8'h00);
        queue_item(OP_ALLOC,   8'h5A, 8'hA5);
        queue_item(OP_ALLOC,   8'h12, 8'h34);
        queue_item(OP_ALLOC,   8'h00, 8'h07);
        queue_item(OP_ALLOC,   8'h00, 8'h00);
        queue_item(OP_ALLOC,   8'h09, 8'h00);
        queue_item(OP_REQUEST, 8'h09, 8'hFF);
        queue_item(OP_REQUEST, 8'h09, 8'h09);
        queue_item(OP_REQUEST, 8'h00, 8'h09);
        queue_item(OP_REQUEST, 8'h00, 8'h00);
        queue_item(OP_REQUEST, 8'h00, 8'h34);
        queue_item(OP_REQUEST, 8'hFF, 8'hA5);
        queue_item(OP_REQUEST, 8'h5A, 8'hA5);
        for (int n = 0; n < 11; n++)
            queue_item(OP_ALLOC, 8'h80 + 8'(n), 8'h40 + 8'(n));
        queue_item(OP_ALLOC, 8'hC3, 8'h3C);

        // random part
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 10)
                queue_item(1'($urandom_range(0, 1)), FIELD_ID_WIDTH'($urandom_range(0, 255)),
                           FIELD_ID_WIDTH'($urandom_range(0, 255)));
            else if (sel < 45)
            begin
                pid = ($urandom_range(0, 3) == 0) ? pick_id(1'b0)
                                                  : FIELD_ID_WIDTH'($urandom_range(0, 255));
                rid = ($urandom_range(0, 3) == 0) ? pick_id(1'b1)
                                                  : FIELD_ID_WIDTH'($urandom_range(0, 255));
                queue_item(OP_ALLOC, pid, rid);
            end
            else
            begin
                pid = ($urandom_range(0, 4) != 0) ? pick_id(1'b0)
                                                  : FIELD_ID_WIDTH'($urandom_range(0, 255));
                rid = ($urandom_range(0, 4) != 0) ? pick_id(1'b1)
                                                  : FIELD_ID_WIDTH'($urandom_range(0, 255));
                queue_item(OP_REQUEST, pid, rid);
            end
        end

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (item_backlog.size() > 0 || item_valid || pending_status.size() > 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);

        if (pending_status.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_status.size()));
        if (error_count == 0)
            $display("tb_rag_deadlock_detector_core OK");
        else
            $display("tb_rag_deadlock_detector_core NOT OK");
        $finish;
    end

endmodule
